FILE: hdl/smd_pkg.sv
// Shared types and constants of the stride mode detector.
`default_nettype none

package smd_pkg;

  localparam int ENTRIES   = 5;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TREE_N    = 1 << IDX_W;
  localparam int ADDR_W    = 64;
  localparam int SCORE_W   = 8;
  localparam int COUNT_W   = 32;
  localparam int THR_W     = 8;

  localparam logic [THR_W-1:0]   THR_RESET  = 8'd40;
  localparam logic [SCORE_W-1:0] SCORE_NEW  = 8'd2;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [SCORE_W-1:0] score_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_LOCK   = 2'd1,
    EV_RELOCK = 2'd2,
    EV_UNLOCK = 2'd3
  } event_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted address
    logic calc;    // form the stride and pick the victim
    logic update;  // update the table and load the result register
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/smd_ctrl.sv
// Controller: sequences each item through stride and update steps.
`default_nettype none

module smd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output smd_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRIDE,
    ST_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_UPDATE) && can_load));
  assign out_valid = out_valid_r;

  always_comb begin
    cmd_o.load   = in_valid && !in_stall;
    cmd_o.calc   = (state_r == ST_STRIDE);
    cmd_o.update = (state_r == ST_UPDATE) && can_load;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_STRIDE;
      end
      ST_STRIDE: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = in_valid ? ST_STRIDE : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_stride_then_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STRIDE) |=> (state_r == ST_UPDATE))
    else $error("stride step not followed by update step");

  a_update_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.update |=> out_valid_r)
    else $error("update did not present a result");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_STRIDE))
    else $error("accepted item did not start processing");

  a_full_out_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && out_valid_r && out_stall) |-> (in_stall && !cmd_o.update))
    else $error("update while result register is held");

endmodule

`default_nettype wire

FILE: hdl/smd_dp.sv
// Datapath: stride, score table, victim search, mode tracking, result register.
`default_nettype none

module smd_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire smd_pkg::cmd_t                 cmd_i,
  input  wire logic [smd_pkg::ADDR_W-1:0]    in_address,
  input  wire logic                          cfg_we,
  input  wire logic [smd_pkg::THR_W-1:0]     cfg_data,
  output logic [1:0]                         out_event_res,
  output logic [smd_pkg::ADDR_W-1:0]         out_stride,
  output logic [smd_pkg::COUNT_W-1:0]        out_count,
  output logic                               out_mode
);

  typedef struct packed {
    logic            vld;
    smd_pkg::score_t score;
    smd_pkg::idx_t   idx;
  } cand_t;

  logic [smd_pkg::ADDR_W-1:0]  addr_r;
  logic [smd_pkg::ADDR_W-1:0]  prev_addr_r;
  logic [smd_pkg::ADDR_W-1:0]  stride_r;
  logic [smd_pkg::ADDR_W-1:0]  stride_abs;
  smd_pkg::idx_t               victim_r;
  logic [smd_pkg::COUNT_W-1:0] count_r;
  logic [smd_pkg::THR_W-1:0]   thr_r;
  logic                        mode_r, mode_nxt;
  smd_pkg::idx_t               locked_r, locked_nxt;
  smd_pkg::score_t             score_r   [smd_pkg::ENTRIES];
  smd_pkg::score_t             score_nxt [smd_pkg::ENTRIES];
  smd_pkg::score_t             gain      [smd_pkg::ENTRIES];
  logic [smd_pkg::ADDR_W-1:0]  stab_r    [smd_pkg::ENTRIES];
  logic [smd_pkg::ENTRIES-1:0] match;
  logic                        hit;
  smd_pkg::idx_t               hit_idx;
  smd_pkg::event_t             ev;
  logic                        clear_count;
  cand_t                       node [2*smd_pkg::TREE_N];

  smd_pkg::event_t             out_event_r;
  logic [smd_pkg::ADDR_W-1:0]  out_stride_r;
  logic [smd_pkg::COUNT_W-1:0] out_count_r;
  logic                        out_mode_r;

  assign stride_abs = (addr_r >= prev_addr_r) ? (addr_r - prev_addr_r)
                                              : (prev_addr_r - addr_r);

  // Victim search on decayed scores; right child wins ties (higher index).
  always_comb begin
    for (int n = 0; n < 2*smd_pkg::TREE_N; n++) node[n] = '0;
    for (int i = 0; i < smd_pkg::ENTRIES; i++) begin
      node[smd_pkg::TREE_N + i].vld   = !(mode_r && (locked_r == smd_pkg::idx_t'(i)));
      node[smd_pkg::TREE_N + i].score = (score_r[i] == '0) ? '0 : score_r[i] - 8'd1;
      node[smd_pkg::TREE_N + i].idx   = smd_pkg::idx_t'(i);
    end
    for (int k = smd_pkg::TREE_N - 1; k >= 1; k--) begin
      if (node[2*k+1].vld && (!node[2*k].vld || (node[2*k+1].score <= node[2*k].score)))
        node[k] = node[2*k+1];
      else
        node[k] = node[2*k];
    end
  end

  // Table update for one stride.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < smd_pkg::ENTRIES; i++) begin
      match[i] = (stab_r[i] == stride_r) && (score_r[i] != '0);
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = smd_pkg::idx_t'(i);
      end
    end
    for (int i = 0; i < smd_pkg::ENTRIES; i++) begin
      if (match[i])
        gain[i] = (score_r[i] >= smd_pkg::SCORE_MAX - 8'd1) ? smd_pkg::SCORE_MAX
                                                            : score_r[i] + 8'd2;
      else
        gain[i] = (score_r[i] == '0) ? '0 : score_r[i] - 8'd1;
      score_nxt[i] = gain[i];
    end
    mode_nxt    = mode_r;
    locked_nxt  = locked_r;
    ev          = smd_pkg::EV_NONE;
    clear_count = 1'b0;
    if (!hit) begin
      score_nxt[victim_r] = smd_pkg::SCORE_NEW;
    end else if (!mode_r) begin
      if (gain[hit_idx] >= thr_r) begin
        mode_nxt    = 1'b1;
        locked_nxt  = hit_idx;
        ev          = smd_pkg::EV_LOCK;
        clear_count = 1'b1;
      end
    end else begin
      if (gain[locked_r] > thr_r) begin
        score_nxt[locked_r] = thr_r;
      end else if (gain[locked_r] == '0) begin
        if (gain[hit_idx] >= thr_r) begin
          score_nxt[hit_idx] = thr_r;
          locked_nxt         = hit_idx;
          ev                 = smd_pkg::EV_RELOCK;
        end else begin
          mode_nxt    = 1'b0;
          ev          = smd_pkg::EV_UNLOCK;
          clear_count = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_addr_r <= '0;
      count_r     <= '0;
      thr_r       <= smd_pkg::THR_RESET;
      mode_r      <= 1'b0;
      locked_r    <= '0;
      for (int i = 0; i < smd_pkg::ENTRIES; i++) score_r[i] <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_data;
      if (cmd_i.calc) begin
        prev_addr_r <= addr_r;
        if (count_r != smd_pkg::COUNT_MAX) count_r <= count_r + 32'd1;
      end
      if (cmd_i.update) begin
        mode_r   <= mode_nxt;
        locked_r <= locked_nxt;
        if (clear_count) count_r <= '0;
        for (int i = 0; i < smd_pkg::ENTRIES; i++) score_r[i] <= score_nxt[i];
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (cmd_i.load) addr_r <= in_address;
    if (cmd_i.calc) begin
      stride_r <= stride_abs;
      victim_r <= node[1].idx;
    end
    if (cmd_i.update) begin
      if (!hit) stab_r[victim_r] <= stride_r;
      out_event_r  <= ev;
      out_stride_r <= (ev != smd_pkg::EV_NONE) ? stride_r : '0;
      out_count_r  <= count_r;
      out_mode_r   <= mode_nxt;
    end
  end

  assign out_event_res = out_event_r;
  assign out_stride    = out_stride_r;
  assign out_count     = out_count_r;
  assign out_mode      = out_mode_r;

endmodule

`default_nettype wire

FILE: hdl/stride_mode_detector.sv
// Top level of the stride mode detector: controller plus datapath.
// Each item passes through the stride step and then the table update step,
// which loads the result register. The next item is accepted in the update
// step of the current one; a held result register stalls the update step.
// Reset (synchronous, rst_n low): clears scores, previous address, mode,
// locked entry and count; the threshold returns to 40. No clearing pass.
`default_nettype none

module stride_mode_detector (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // address items in
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [smd_pkg::ADDR_W-1:0]    in_address,
  // result items out
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_event_res,
  output logic [smd_pkg::ADDR_W-1:0]         out_stride,
  output logic [smd_pkg::COUNT_W-1:0]        out_count,
  output logic                               out_mode,
  // threshold register write
  input  wire logic                          cfg_we,
  input  wire logic [smd_pkg::THR_W-1:0]     cfg_data
);

  smd_pkg::cmd_t cmd;

  // Controller: accept an item, form its stride, then update the table
  // once the result register is free. The next item is taken in the same
  // cycle as the update, so items overlap by one step.
  smd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd)
  );

  // Datapath: the stride step also picks the miss victim from the decayed
  // scores, since the table does not change before the update step.
  smd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .in_address    (in_address),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_event_res (out_event_res),
    .out_stride    (out_stride),
    .out_count     (out_count),
    .out_mode      (out_mode)
  );

endmodule

`default_nettype wire
